>>> hdl/bolc_pkg.sv
// shared types and byte codes for the backspace overstrike line converter
package bolc_pkg;

  localparam int COL_W = 6;

  localparam logic [7:0] BYTE_BS   = 8'h08;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_FF   = 8'h0C;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_EOT  = 8'h1A;
  localparam logic [7:0] CODE_SKIP = 8'h20;
  localparam logic [7:0] CODE_OVER = 8'h2B;
  localparam logic [7:0] CODE_FORM = 8'h31;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic             ovr;
    logic             has_char;
    logic [COL_W-1:0] pad_cnt;
    logic [7:0]       ch;
  } cmd_t;

endpackage

>>> hdl/bolc_front.sv
// front end: accepts text bytes, tracks columns and queues line commands
module bolc_front #(
  parameter int LINE_WIDTH = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bolc_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output bolc_pkg::cmd_t    q_cmd
);

  logic [bolc_pkg::COL_W-1:0] column_r, column_nxt;
  logic [bolc_pkg::COL_W-1:0] target_r, target_nxt;
  logic [bolc_pkg::COL_W-1:0] col_after;
  logic                       accept, eot, bs, ovr, skip;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    eot        = in_data.end_of_text | (in_data.ch == bolc_pkg::BYTE_EOT);
    bs         = ~eot & (in_data.ch == bolc_pkg::BYTE_BS);
    ovr        = target_r < column_r;
    skip       = ~ovr & (column_r == bolc_pkg::COL_W'(1)) & ~eot;
    col_after  = ovr ? target_r : column_r;
    column_nxt = column_r;
    target_nxt = target_r;
    q_push     = 1'b0;

    q_cmd.ovr      = ovr;
    q_cmd.has_char = ~eot;
    q_cmd.ch       = in_data.ch;
    if (ovr) begin
      q_cmd.pad_cnt = target_r - bolc_pkg::COL_W'(1);
    end else if (skip) begin
      q_cmd.pad_cnt = bolc_pkg::COL_W'(1);
    end else begin
      q_cmd.pad_cnt = '0;
    end

    if (accept) begin
      if (bs) begin
        if (target_r > bolc_pkg::COL_W'(1)) begin
          target_nxt = target_r - bolc_pkg::COL_W'(1);
        end
      end else begin
        q_push = ovr | skip | ~eot;
        if (eot) begin
          column_nxt = bolc_pkg::COL_W'(1);
        end else if (in_data.ch == bolc_pkg::BYTE_LF) begin
          column_nxt = bolc_pkg::COL_W'(1);
        end else if (col_after < bolc_pkg::COL_W'(LINE_WIDTH)) begin
          column_nxt = col_after + bolc_pkg::COL_W'(1);
        end else begin
          column_nxt = col_after;
        end
        target_nxt = column_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= bolc_pkg::COL_W'(1);
      target_r <= bolc_pkg::COL_W'(1);
    end else begin
      column_r <= column_nxt;
      target_r <= target_nxt;
    end
  end

endmodule

>>> hdl/bolc_queue.sv
// two-entry command queue between front and back end
module bolc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bolc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bolc_pkg::cmd_t head
);

  bolc_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/bolc_back.sv
// back end: expands line commands into codes and maps carriage control
module bolc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  bolc_pkg::cmd_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bolc_pkg::out_item_t out_data
);

  localparam logic [1:0] PH_LF   = 2'd0;
  localparam logic [1:0] PH_PLUS = 2'd1;
  localparam logic [1:0] PH_PAD  = 2'd2;
  localparam logic [1:0] PH_CHAR = 2'd3;

  logic [1:0]                 ph_r, ph_nxt, cur_ph, first_ph;
  logic [bolc_pkg::COL_W-1:0] pad_r, pad_nxt, cur_pad;
  logic                       busy_r, busy_nxt;
  logic                       pend_r, pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bolc_pkg::out_item_t        out_data_r;
  logic [7:0]                 code, pbyte;
  logic                       last, load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = head_valid & (~out_valid_r | ~out_stall);
  assign pop       = load & last;

  always_comb begin
    if (head.ovr) begin
      first_ph = PH_LF;
    end else if (head.pad_cnt != '0) begin
      first_ph = PH_PAD;
    end else begin
      first_ph = PH_CHAR;
    end
    cur_ph  = busy_r ? ph_r : first_ph;
    cur_pad = busy_r ? pad_r : head.pad_cnt;
    pad_nxt = cur_pad;
    ph_nxt  = PH_CHAR;
    last    = 1'b0;
    case (cur_ph)
      PH_LF: begin
        code   = bolc_pkg::BYTE_LF;
        ph_nxt = PH_PLUS;
      end
      PH_PLUS: begin
        code = bolc_pkg::CODE_OVER;
        if (cur_pad != '0) begin
          ph_nxt = PH_PAD;
        end else begin
          last = ~head.has_char;
        end
      end
      PH_PAD: begin
        code    = bolc_pkg::CODE_SKIP;
        pad_nxt = cur_pad - bolc_pkg::COL_W'(1);
        if (pad_nxt != '0) begin
          ph_nxt = PH_PAD;
        end else begin
          last = ~head.has_char;
        end
      end
      default: begin
        code = head.ch;
        last = 1'b1;
      end
    endcase

    pend_nxt = pend_r;
    pbyte    = code;
    if (pend_r) begin
      pend_nxt = 1'b0;
      if (code == bolc_pkg::BYTE_LF) begin
        pbyte    = bolc_pkg::BYTE_LF;
        pend_nxt = 1'b1;
      end else if (code == bolc_pkg::CODE_OVER) begin
        pbyte = bolc_pkg::BYTE_CR;
      end else if (code == bolc_pkg::CODE_SKIP) begin
        pbyte = bolc_pkg::BYTE_LF;
      end else if (code == bolc_pkg::CODE_FORM) begin
        pbyte = bolc_pkg::BYTE_FF;
      end
    end else if (code == bolc_pkg::BYTE_LF) begin
      pbyte    = bolc_pkg::BYTE_CR;
      pend_nxt = 1'b1;
    end

    busy_nxt      = load ? ~last : busy_r;
    out_valid_nxt = load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ph_r                <= ph_nxt;
      pad_r               <= pad_nxt;
      out_data_r.out_byte <= pbyte;
      out_data_r.last     <= last;
    end
  end

endmodule

>>> hdl/backspace_overstrike_line_converter.sv
// top level of the backspace overstrike to carriage control converter
//
//   channel  direction  payload                     handshake
//   in       input      in_data (ch, end_of_text)   in_valid / in_stall
//   out      output     out_data (out_byte, last)   out_valid / out_stall
//
// an item giving one byte or none does not set the back end busy; the front
// end takes one item per cycle while the two-entry command queue has room
// an item that gives n bytes keeps the back end busy to its last byte, one
// byte a cycle into the output register unless out_stall holds it
// a command is held in the queue, its bytes then in the output register
// reset is synchronous, active low; column and target return to one
// out_stall holds the output register and back end, the queue then fills
// and raises in_stall
module backspace_overstrike_line_converter #(
  parameter int LINE_WIDTH = 60
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bolc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bolc_pkg::out_item_t out_data
);

  logic           q_push, q_full, q_pop, q_head_valid;
  bolc_pkg::cmd_t q_cmd, q_head;

  bolc_front #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  bolc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  bolc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
